[hdl/tfn_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfn_pkg
// shared constants, types and width helpers for the triangle face normal block
// ----------------------------------------------------------------------------
`default_nettype none

package tfn_pkg;

  localparam int COORD_WIDTH_DEF      = 20;
  localparam int NORMAL_FRAC_BITS_DEF = 14;
  localparam int OUT_WIDTH            = 16;
  // normalized magnitude window, msb of the largest lands at bit 29
  localparam int NORM_WIDTH           = 30;
  localparam int LEN_WIDTH            = 31;

  typedef struct packed {
    logic [2:0] neg;
    logic       zero;
  } side_t;

  // edge width after the optional magnitude pre-shift
  function automatic int edge_width(input int cw);
    return (cw + 1 > 31) ? 32 : cw + 1;
  endfunction

  function automatic int pre_shift(input int cw);
    return (cw > 30) ? cw - 30 : 0;
  endfunction

endpackage

`default_nettype wire

[hdl/tfn_cross.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfn_cross
// edges, cross product and component magnitudes in three register stages
// ----------------------------------------------------------------------------
`default_nettype none

module tfn_cross #(
  parameter int CW = tfn_pkg::COORD_WIDTH_DEF,
  localparam int EW = tfn_pkg::edge_width(CW),
  localparam int MW = 2 * EW
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire logic                 in_valid,
  input  wire logic signed [CW-1:0] a_x,
  input  wire logic signed [CW-1:0] a_y,
  input  wire logic signed [CW-1:0] a_z,
  input  wire logic signed [CW-1:0] b_x,
  input  wire logic signed [CW-1:0] b_y,
  input  wire logic signed [CW-1:0] b_z,
  input  wire logic signed [CW-1:0] c_x,
  input  wire logic signed [CW-1:0] c_y,
  input  wire logic signed [CW-1:0] c_z,
  output logic                      out_valid,
  output logic [MW-1:0]             mag [3],
  output logic [2:0]                neg
);

  localparam int PRE = tfn_pkg::pre_shift(CW);

  logic [CW-1:0] pa [3];
  logic [CW-1:0] pb [3];
  logic [CW-1:0] pc [3];

  logic signed [EW-1:0] e1 [3];
  logic signed [EW-1:0] e2 [3];
  logic signed [MW-1:0] prod [6];
  logic signed [MW:0]   xd [3];
  logic [MW:0]          xm [3];
  logic [2:0]           vld;

  assign pa[0] = a_x;
  assign pa[1] = a_y;
  assign pa[2] = a_z;
  assign pb[0] = b_x;
  assign pb[1] = b_y;
  assign pb[2] = b_z;
  assign pc[0] = c_x;
  assign pc[1] = c_y;
  assign pc[2] = c_z;

  // q - p with the magnitude shifted right, truncating toward zero
  function automatic logic [EW-1:0] edge_of(input logic [CW-1:0] p, input logic [CW-1:0] q);
    logic [CW:0] d;
    logic [CW:0] m;
    logic [CW:0] sh;
    logic [CW:0] res;
    d   = {q[CW-1], q} - {p[CW-1], p};
    m   = d[CW] ? (~d + 1'b1) : d;
    sh  = m >> PRE;
    res = d[CW] ? (~sh + 1'b1) : sh;
    return res[EW-1:0];
  endfunction

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      xd[i] = {prod[2*i][MW-1], prod[2*i]} - {prod[2*i+1][MW-1], prod[2*i+1]};
      xm[i] = xd[i][MW] ? (~xd[i] + 1'b1) : xd[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e1[i] <= edge_of(pa[i], pb[i]);
        e2[i] <= edge_of(pa[i], pc[i]);
      end
      prod[0] <= e1[1] * e2[2];
      prod[1] <= e1[2] * e2[1];
      prod[2] <= e1[2] * e2[0];
      prod[3] <= e1[0] * e2[2];
      prod[4] <= e1[0] * e2[1];
      prod[5] <= e1[1] * e2[0];
      for (int i = 0; i < 3; i++) begin
        mag[i] <= xm[i][MW-1:0];
        neg[i] <= xd[i][MW];
      end
    end
  end

  assign out_valid = vld[2];

endmodule

`default_nettype wire

[hdl/tfn_norm.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfn_norm
// common power-of-two scaling of the three magnitudes, one binary step a stage
// ----------------------------------------------------------------------------
`default_nettype none

module tfn_norm #(
  parameter int MW = 42
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           en,
  input  wire logic           in_valid,
  input  wire logic [MW-1:0]  mag [3],
  input  wire logic [2:0]     neg,
  output logic                out_valid,
  output logic [tfn_pkg::NORM_WIDTH-1:0] m_out [3],
  output tfn_pkg::side_t      side
);

  localparam int NW = (MW > tfn_pkg::NORM_WIDTH) ? MW : tfn_pkg::NORM_WIDTH;
  localparam int NS = $clog2(NW);

  logic [NW-1:0]  st [NS][3];
  logic [NW-1:0]  st_next [NS][3];
  tfn_pkg::side_t sd [NS];
  tfn_pkg::side_t base_sd;
  logic [NS-1:0]  vld;

  assign base_sd.neg  = neg;
  assign base_sd.zero = ((mag[0] | mag[1] | mag[2]) == '0);

  always_comb begin
    int s;
    logic [NW-1:0] src [3];
    logic [NW-1:0] orv;
    for (int k = 0; k < NS; k++) begin
      s = 1 << (NS - 1 - k);
      for (int i = 0; i < 3; i++) begin
        src[i] = (k == 0) ? NW'(mag[i]) : st[(k == 0) ? 0 : k - 1][i];
      end
      orv = src[0] | src[1] | src[2];
      // shift left when the top s bits of the largest are all clear
      for (int i = 0; i < 3; i++) begin
        st_next[k][i] = ((orv >> (NW - s)) == '0) ? (src[i] << s) : src[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st    <= st_next;
      sd[0] <= base_sd;
      for (int k = 1; k < NS; k++) begin
        sd[k] <= sd[k-1];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m_out[i] = st[NS-1][i][NW-1 -: tfn_pkg::NORM_WIDTH];
    end
  end

  assign out_valid = vld[NS-1];
  assign side      = sd[NS-1];

endmodule

`default_nettype wire

[hdl/tfn_sqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfn_sqrt
// sum of squares and a pipelined integer square root, one root bit a stage
// ----------------------------------------------------------------------------
`default_nettype none

module tfn_sqrt (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           en,
  input  wire logic           in_valid,
  input  wire logic [tfn_pkg::NORM_WIDTH-1:0] m_in [3],
  input  wire tfn_pkg::side_t side_in,
  output logic                out_valid,
  output logic [tfn_pkg::NORM_WIDTH-1:0] m_out [3],
  output logic [tfn_pkg::LEN_WIDTH-1:0]  len,
  output tfn_pkg::side_t      side_out
);

  localparam int NWD = tfn_pkg::NORM_WIDTH;
  localparam int RS  = tfn_pkg::LEN_WIDTH;
  localparam int SW  = 2 * RS;

  logic [2*NWD-1:0] sq [3];
  logic [NWD-1:0]   ma [3];
  logic [NWD-1:0]   mb [3];
  tfn_pkg::side_t   sda;
  tfn_pkg::side_t   sdb;
  logic [SW-1:0]    sum;
  logic             va;
  logic             vb;

  logic [RS+1:0]  rem [RS];
  logic [RS-1:0]  root [RS];
  logic [SW-1:0]  rad [RS];
  logic [NWD-1:0] mm [RS][3];
  tfn_pkg::side_t sd [RS];
  logic [RS-1:0]  vld;

  logic [RS+1:0]  rem_next [RS];
  logic [RS-1:0]  root_next [RS];
  logic [SW-1:0]  rad_next [RS];

  always_comb begin
    logic [RS+1:0] r;
    logic [RS-1:0] q;
    logic [SW-1:0] s;
    logic [RS+3:0] rn;
    logic [RS+3:0] t;
    for (int k = 0; k < RS; k++) begin
      r = (k == 0) ? '0  : rem[(k == 0) ? 0 : k - 1];
      q = (k == 0) ? '0  : root[(k == 0) ? 0 : k - 1];
      s = (k == 0) ? sum : rad[(k == 0) ? 0 : k - 1];
      rn = {r, s[SW-1 -: 2]};
      t  = {2'b00, q, 2'b01};
      if (rn >= t) begin
        rem_next[k]  = (RS+2)'(rn - t);
        root_next[k] = {q[RS-2:0], 1'b1};
      end else begin
        rem_next[k]  = rn[RS+1:0];
        root_next[k] = {q[RS-2:0], 1'b0};
      end
      rad_next[k] = s << 2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va  <= 1'b0;
      vb  <= 1'b0;
      vld <= '0;
    end else if (en) begin
      va  <= in_valid;
      vb  <= va;
      vld <= {vld[RS-2:0], vb};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq[i] <= m_in[i] * m_in[i];
      end
      ma  <= m_in;
      sda <= side_in;
      sum <= SW'(sq[0]) + SW'(sq[1]) + SW'(sq[2]);
      mb  <= ma;
      sdb <= sda;
      rem  <= rem_next;
      root <= root_next;
      rad  <= rad_next;
      mm[0] <= mb;
      sd[0] <= sdb;
      for (int k = 1; k < RS; k++) begin
        mm[k] <= mm[k-1];
        sd[k] <= sd[k-1];
      end
    end
  end

  assign out_valid = vld[RS-1];
  assign m_out     = mm[RS-1];
  assign len       = root[RS-1];
  assign side_out  = sd[RS-1];

endmodule

`default_nettype wire

[hdl/tfn_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfn_div
// rounded division of each magnitude by the length, one quotient bit a stage,
// then sign and the output register
// ----------------------------------------------------------------------------
`default_nettype none

module tfn_div #(
  parameter int F = tfn_pkg::NORMAL_FRAC_BITS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           en,
  input  wire logic           in_valid,
  input  wire logic [tfn_pkg::NORM_WIDTH-1:0] m_in [3],
  input  wire logic [tfn_pkg::LEN_WIDTH-1:0]  len_in,
  input  wire tfn_pkg::side_t side_in,
  output logic                out_valid,
  output logic signed [tfn_pkg::OUT_WIDTH-1:0] normal_x,
  output logic signed [tfn_pkg::OUT_WIDTH-1:0] normal_y,
  output logic signed [tfn_pkg::OUT_WIDTH-1:0] normal_z,
  output logic                degenerate
);

  localparam int NWD = tfn_pkg::NORM_WIDTH;
  localparam int LW  = tfn_pkg::LEN_WIDTH;
  localparam int OW  = tfn_pkg::OUT_WIDTH;
  localparam int NNW = NWD + F + 1;
  localparam int QS  = F + 1;

  logic [NNW-1:0]  num [3];
  logic [LW-1:0]   len0;
  tfn_pkg::side_t  sd0;
  logic            v0;

  logic [LW-1:0]   rem [QS][3];
  logic [F:0]      lo [QS][3];
  logic [F:0]      quo [QS][3];
  logic [LW-1:0]   ln [QS];
  tfn_pkg::side_t  sd [QS];
  logic [QS-1:0]   vld;

  logic [LW-1:0]   rem_next [QS][3];
  logic [F:0]      lo_next [QS][3];
  logic [F:0]      quo_next [QS][3];
  logic signed [OW-1:0] res [3];
  logic            vout;

  always_comb begin
    logic [LW-1:0] r;
    logic [F:0]    l;
    logic [F:0]    q;
    logic [LW-1:0] d;
    logic [LW:0]   t;
    for (int k = 0; k < QS; k++) begin
      d = (k == 0) ? len0 : ln[(k == 0) ? 0 : k - 1];
      for (int i = 0; i < 3; i++) begin
        if (k == 0) begin
          r = LW'(num[i][NNW-1:F+1]);
          l = num[i][F:0];
          q = '0;
        end else begin
          r = rem[(k == 0) ? 0 : k - 1][i];
          l = lo[(k == 0) ? 0 : k - 1][i];
          q = quo[(k == 0) ? 0 : k - 1][i];
        end
        t = {r, l[F]};
        if (t >= {1'b0, d}) begin
          rem_next[k][i] = LW'(t - {1'b0, d});
          quo_next[k][i] = {q[F-1:0], 1'b1};
        end else begin
          rem_next[k][i] = t[LW-1:0];
          quo_next[k][i] = {q[F-1:0], 1'b0};
        end
        lo_next[k][i] = l << 1;
      end
    end
  end

  always_comb begin
    logic [63:0] w;
    for (int i = 0; i < 3; i++) begin
      w = 64'(quo[QS-1][i]);
      if (sd[QS-1].neg[i]) begin
        w = ~w + 64'd1;
      end
      res[i] = sd[QS-1].zero ? '0 : w[OW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0   <= 1'b0;
      vld  <= '0;
      vout <= 1'b0;
    end else if (en) begin
      v0   <= in_valid;
      vld  <= {vld[QS-2:0], v0};
      vout <= vld[QS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // numerator m * 2^F + len / 2 gives round half up
      for (int i = 0; i < 3; i++) begin
        num[i] <= {1'b0, m_in[i], F'(0)} + NNW'(len_in[LW-1:1]);
      end
      len0  <= len_in;
      sd0   <= side_in;
      rem   <= rem_next;
      lo    <= lo_next;
      quo   <= quo_next;
      ln[0] <= len0;
      sd[0] <= sd0;
      for (int k = 1; k < QS; k++) begin
        ln[k] <= ln[k-1];
        sd[k] <= sd[k-1];
      end
      normal_x   <= res[0];
      normal_y   <= res[1];
      normal_z   <= res[2];
      degenerate <= sd[QS-1].zero;
    end
  end

  assign out_valid = vout;

endmodule

`default_nettype wire

[hdl/triangle_face_normal_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_face_normal_top
// unit face normal of a triangle: cross product of the edge vectors b - a and
// c - a, scaled to length one in Q1.14, with a flag for a zero cross product
// ----------------------------------------------------------------------------
// throughput: one item per cycle; the whole pipe advances together and
//   holds while a result is stalled at the output register
// reset clears the valid bits and the skid only; nothing else is cleared
`default_nettype none

module triangle_face_normal_top #(
  parameter int COORD_WIDTH      = tfn_pkg::COORD_WIDTH_DEF,
  parameter int NORMAL_FRAC_BITS = tfn_pkg::NORMAL_FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          tri_valid,
  output logic                               tri_stall,
  input  wire logic signed [COORD_WIDTH-1:0] a_x,
  input  wire logic signed [COORD_WIDTH-1:0] a_y,
  input  wire logic signed [COORD_WIDTH-1:0] a_z,
  input  wire logic signed [COORD_WIDTH-1:0] b_x,
  input  wire logic signed [COORD_WIDTH-1:0] b_y,
  input  wire logic signed [COORD_WIDTH-1:0] b_z,
  input  wire logic signed [COORD_WIDTH-1:0] c_x,
  input  wire logic signed [COORD_WIDTH-1:0] c_y,
  input  wire logic signed [COORD_WIDTH-1:0] c_z,
  output logic                               norm_valid,
  input  wire logic                          norm_stall,
  output logic signed [tfn_pkg::OUT_WIDTH-1:0] normal_x,
  output logic signed [tfn_pkg::OUT_WIDTH-1:0] normal_y,
  output logic signed [tfn_pkg::OUT_WIDTH-1:0] normal_z,
  output logic                               degenerate
);

  localparam int CW  = COORD_WIDTH;
  localparam int EW  = tfn_pkg::edge_width(CW);
  localparam int MW  = 2 * EW;
  localparam int NWD = tfn_pkg::NORM_WIDTH;

  logic en;
  logic skid_valid;
  logic signed [CW-1:0] skid [9];
  logic signed [CW-1:0] cur [9];
  logic signed [CW-1:0] port [9];
  logic feed_valid;

  logic           x_valid;
  logic [MW-1:0]  x_mag [3];
  logic [2:0]     x_neg;
  logic           n_valid;
  logic [NWD-1:0] n_m [3];
  tfn_pkg::side_t n_side;
  logic           s_valid;
  logic [NWD-1:0] s_m [3];
  logic [tfn_pkg::LEN_WIDTH-1:0] s_len;
  tfn_pkg::side_t s_side;

  assign en = !(norm_valid && norm_stall);

  assign port[0] = a_x;
  assign port[1] = a_y;
  assign port[2] = a_z;
  assign port[3] = b_x;
  assign port[4] = b_y;
  assign port[5] = b_z;
  assign port[6] = c_x;
  assign port[7] = c_y;
  assign port[8] = c_z;

  // skid holds the item taken in the cycle the pipe stalled
  assign tri_stall  = skid_valid;
  assign feed_valid = skid_valid || tri_valid;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      cur[i] = skid_valid ? skid[i] : port[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (en) begin
      skid_valid <= 1'b0;
    end else if (tri_valid && !skid_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!en && !skid_valid) begin
      skid <= port;
    end
  end

  tfn_cross #(.CW(CW)) u_cross (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (feed_valid),
    .a_x      (cur[0]),
    .a_y      (cur[1]),
    .a_z      (cur[2]),
    .b_x      (cur[3]),
    .b_y      (cur[4]),
    .b_z      (cur[5]),
    .c_x      (cur[6]),
    .c_y      (cur[7]),
    .c_z      (cur[8]),
    .out_valid(x_valid),
    .mag      (x_mag),
    .neg      (x_neg)
  );

  tfn_norm #(.MW(MW)) u_norm (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (x_valid),
    .mag      (x_mag),
    .neg      (x_neg),
    .out_valid(n_valid),
    .m_out    (n_m),
    .side     (n_side)
  );

  tfn_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (n_valid),
    .m_in     (n_m),
    .side_in  (n_side),
    .out_valid(s_valid),
    .m_out    (s_m),
    .len      (s_len),
    .side_out (s_side)
  );

  tfn_div #(.F(NORMAL_FRAC_BITS)) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_valid),
    .m_in      (s_m),
    .len_in    (s_len),
    .side_in   (s_side),
    .out_valid (norm_valid),
    .normal_x  (normal_x),
    .normal_y  (normal_y),
    .normal_z  (normal_z),
    .degenerate(degenerate)
  );

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    norm_valid && degenerate |-> normal_x == '0 && normal_y == '0 && normal_z == '0)
    else $error("degenerate result with nonzero normal");

  a_nondegen_nonzero: assert property (@(posedge clk) disable iff (rst)
    norm_valid && !degenerate |-> normal_x != '0 || normal_y != '0 || normal_z != '0)
    else $error("zero normal without degenerate flag");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(norm_valid && norm_stall && tri_valid))
    else $error("skid filled while the pipe was moving");

  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    skid_valid && en |=> !skid_valid)
    else $error("skid not drained when the pipe advanced");

endmodule

`default_nettype wire
